[hdl/bts_pkg.sv]
// Shared types and constants for the BM25 term score pipeline.
// Holds the per-stage record, the stage numbering and the status and register codes.
// No dependencies.
package bts_pkg;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BOOST = 2'd1;
  localparam logic [1:0] STAT_STATS = 2'd2;

  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_WEIGHT = 1'b1;

  localparam logic [15:0] GAIN_RESET   = 16'd4915;
  localparam logic [16:0] WEIGHT_RESET = 17'd49152;
  localparam logic [16:0] ONE_Q16      = 17'h10000;
  localparam logic [16:0] ONE_Q12      = 17'h01000;
  localparam logic [31:0] LN2_Q32      = 32'hB172_17F8;
  localparam logic [39:0] REL_MAX      = 40'hFF_FFFF_FFFF;

  localparam int ST_CHK  = 1;
  localparam int ST_ENC  = 2;
  localparam int ST_NRM  = 3;
  localparam int ST_SQ0  = 4;
  localparam int SQ_N    = 24;
  localparam int ST_DIFF = ST_SQ0 + SQ_N;
  localparam int ST_IDF  = ST_DIFF + 1;
  localparam int ST_RAT0 = 2;
  localparam int RAT_N   = 56;
  localparam int ST_INB  = ST_RAT0 + RAT_N;
  localparam int ST_INS  = ST_INB + 1;
  localparam int ST_NMP  = ST_INS + 1;
  localparam int ST_NMS  = ST_NMP + 1;
  localparam int ST_DEN  = ST_NMS + 1;
  localparam int ST_FW0  = ST_DEN + 1;
  localparam int FW_N    = 29;
  localparam int ST_P1   = ST_FW0 + FW_N;
  localparam int ST_P2   = ST_P1 + 1;
  localparam int ST_P3   = ST_P2 + 1;
  localparam int ST_SUM  = ST_P3 + 1;
  localparam int ST_OUT  = ST_SUM + 1;

  typedef struct packed {
    logic [1:0]  stat;
    logic        zero;
    logic [31:0] tf;
    logic [31:0] len;
    logic [31:0] df;
    logic [31:0] nd;
    logic [31:0] avg;
    logic [15:0] fbr;
    logic [15:0] qbr;
    logic [15:0] k;
    logic [16:0] b;
    logic [33:0] xa;
    logic [33:0] xb;
    logic [5:0]  ea;
    logic [5:0]  eb;
    logic [30:0] ma;
    logic [30:0] mb;
    logic [29:0] la;
    logic [29:0] lb;
    logic [29:0] idf;
    logic [55:0] dq;
    logic [31:0] drem;
    logic [40:0] p1;
    logic [32:0] p2;
    logic [32:0] p3;
    logic [57:0] inner;
    logic [39:0] q1;
    logic [33:0] q2;
    logic [31:0] q3;
    logic [48:0] num;
    logic [58:0] norm;
    logic [59:0] den;
    logic [59:0] frem;
    logic [28:0] fq;
    logic [34:0] pa;
    logic [41:0] pb;
    logic [46:0] pl;
    logic [24:0] ph;
    logic [56:0] psum;
    logic [39:0] rel;
  } stage_t;

  typedef struct packed {
    logic [1:0]  stat;
    logic [39:0] rel;
  } result_t;

endpackage

[hdl/bm25_term_score.sv]
// Channel   Dir  Fields (tdata from bit 0 up)
// in_*      in   term_count, doc_length, docs_with_term, corpus_docs, mean_doc_length,
//                field_weight, query_weight
// out_*     out  relevance, status
// cfg_*     in   register index, write data
// One request enters per cycle while the two-entry output buffer is not full.
// Depth is set by the 56 bit-steps of the length ratio division and the 29 bit-steps of
// the frequency weight division, each one register stage.
// Reset empties the pipeline and the two-entry output buffer and restores the registers.
// A full output buffer holds the whole pipeline; no request is lost or repeated.
// Depends on bts_pkg.
module bm25_term_score
  import bts_pkg::*;
#(
  parameter int COUNT_BITS          = 32,
  parameter int SCORE_FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // term_count, doc_length, docs_with_term, corpus_docs, mean_doc_length,
  // field_weight, query_weight
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // relevance, status, zero fill
  output logic [47:0]  out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [16:0]  cfg_data
);

  localparam int LAST = ST_OUT;
  localparam logic [31:0] CNT_MASK = 32'((64'd1 << COUNT_BITS) - 64'd1);
  localparam int SHR = 32 - SCORE_FRACTION_BITS;

  logic [15:0] gain_r;
  logic [16:0] weight_r;
  stage_t      pipe_r [0:LAST];
  stage_t      nxt    [0:LAST];
  logic [LAST:0] vld_r;
  result_t     buf_r [0:1];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        en;
  logic        push;
  logic        pop;

  function automatic logic [5:0] msb_pos(input logic [33:0] x);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 34; i++) begin
      if (x[i]) pos = 6'(i);
    end
    return pos;
  endfunction

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;
  assign push      = en && vld_r[LAST];
  assign pop       = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata = {6'b0, buf_r[rd_ptr_r].stat, buf_r[rd_ptr_r].rel};

  always_comb begin
    nxt[0]     = pipe_r[0];
    nxt[0].tf  = in_tdata[31:0] & CNT_MASK;
    nxt[0].len = in_tdata[63:32] & CNT_MASK;
    nxt[0].df  = in_tdata[95:64] & CNT_MASK;
    nxt[0].nd  = in_tdata[127:96] & CNT_MASK;
    nxt[0].avg = in_tdata[159:128];
    nxt[0].fbr = in_tdata[175:160];
    nxt[0].qbr = in_tdata[191:176];
  end

  for (genvar j = 1; j <= LAST; j++) begin : g_stage
    localparam int LBIT = (j >= ST_SQ0 && j < ST_SQ0 + SQ_N) ? (SQ_N - 1 - (j - ST_SQ0)) : 0;
    always_comb begin
      stage_t      s;
      logic [61:0] sqa;
      logic [61:0] sqb;
      logic [32:0] r2;
      logic [60:0] f2;
      logic [61:0] dl;
      logic [58:0] pf;
      logic [49:0] pw;
      logic [33:0] sha;
      logic [33:0] shb;
      logic [56:0] sh;
      logic        ge;
      logic        negb;
      logic        incons;
      s = pipe_r[j-1];
      sqa = '0; sqb = '0; r2 = '0; f2 = '0; dl = '0; pf = '0; pw = '0;
      sha = '0; shb = '0; sh = '0; ge = 1'b0; negb = 1'b0; incons = 1'b0;
      if (j == ST_CHK) begin
        negb = s.fbr[15] | s.qbr[15];
        incons = (s.df > s.nd) || ((s.tf != '0) &&
                 ((s.df == '0) || (s.nd == '0) || (s.avg == '0) || (s.tf > s.len)));
        s.stat = negb ? STAT_BOOST : (incons ? STAT_STATS : STAT_OK);
        s.zero = (s.tf == '0) || (s.df == '0) || (s.nd == '0) || (s.fbr == '0) ||
                 (s.qbr == '0) || (s.avg == '0);
        s.xa   = {1'b0, s.nd, 1'b0} + 34'd2;
        s.xb   = {1'b0, s.df, 1'b1};
        s.k    = gain_r;
        s.b    = (weight_r > ONE_Q16) ? ONE_Q16 : weight_r;
        s.dq   = {s.len, 24'b0};
        s.drem = '0;
      end
      if (j == ST_ENC) begin
        s.ea = msb_pos(s.xa);
        s.eb = msb_pos(s.xb);
      end
      if (j == ST_NRM) begin
        sha  = s.xa << (6'd33 - s.ea);
        shb  = s.xb << (6'd33 - s.eb);
        s.ma = sha[33:3];
        s.mb = shb[33:3];
        s.la = {s.ea, 24'b0};
        s.lb = {s.eb, 24'b0};
      end
      if (j >= ST_SQ0 && j < ST_SQ0 + SQ_N) begin
        sqa = 62'(s.ma) * 62'(s.ma);
        sqb = 62'(s.mb) * 62'(s.mb);
        if (sqa[61]) begin
          s.ma = sqa[61:31];
          s.la[LBIT] = 1'b1;
        end else begin
          s.ma = sqa[60:30];
        end
        if (sqb[61]) begin
          s.mb = sqb[61:31];
          s.lb[LBIT] = 1'b1;
        end else begin
          s.mb = sqb[60:30];
        end
      end
      if (j == ST_DIFF) begin
        s.idf = (s.la > s.lb) ? (s.la - s.lb) : '0;
      end
      if (j == ST_IDF) begin
        dl    = 62'(s.idf) * 62'(LN2_Q32);
        s.idf = dl[61:32];
      end
      if (j >= ST_RAT0 && j < ST_RAT0 + RAT_N) begin
        r2 = {s.drem, s.dq[55]};
        ge = (r2 >= {1'b0, s.avg});
        s.drem = ge ? 32'(r2 - {1'b0, s.avg}) : r2[31:0];
        s.dq   = {s.dq[54:0], ge};
      end
      if (j == ST_INB) begin
        s.p1 = 41'(s.b) * 41'(s.dq[39:16]);
        s.p2 = 33'(s.b) * 33'(s.dq[55:40]);
        s.p3 = 33'(s.b) * 33'(s.dq[15:0]);
      end
      if (j == ST_INS) begin
        s.inner = 58'(ONE_Q16 - s.b) + 58'(s.p1) + 58'({s.p2, 24'b0}) + 58'(s.p3[32:16]);
      end
      if (j == ST_NMP) begin
        s.q1  = 40'(s.k) * 40'(s.inner[39:16]);
        s.q2  = 34'(s.k) * 34'(s.inner[57:40]);
        s.q3  = 32'(s.k) * 32'(s.inner[15:0]);
        s.num = 49'(s.tf) * 49'({1'b0, s.k} + ONE_Q12);
      end
      if (j == ST_NMS) begin
        s.norm = 59'(s.q1) + 59'({s.q2, 24'b0}) + 59'(s.q3[31:16]);
      end
      if (j == ST_DEN) begin
        s.den  = 60'(s.norm) + 60'({s.tf, 12'b0});
        s.frem = 60'(s.num[48:5]);
        s.fq   = {s.num[4:0], 24'b0};
      end
      if (j >= ST_FW0 && j < ST_FW0 + FW_N) begin
        f2 = {s.frem, s.fq[28]};
        ge = (f2 >= {1'b0, s.den});
        s.frem = ge ? 60'(f2 - {1'b0, s.den}) : f2[59:0];
        s.fq   = {s.fq[27:0], ge};
      end
      if (j == ST_P1) begin
        pf   = 59'(s.idf) * 59'(s.fq);
        s.pa = pf[58:24];
      end
      if (j == ST_P2) begin
        pw   = 50'(s.pa) * 50'(s.fbr[14:0]);
        s.pb = pw[49:8];
      end
      if (j == ST_P3) begin
        s.pl = 47'(s.pb[31:0]) * 47'(s.qbr[14:0]);
        s.ph = 25'(s.pb[41:32]) * 25'(s.qbr[14:0]);
      end
      if (j == ST_SUM) begin
        s.psum = 57'(s.pl) + {s.ph, 32'b0};
      end
      if (j == ST_OUT) begin
        sh = s.psum >> SHR;
        if ((s.stat != STAT_OK) || s.zero) begin
          s.rel = '0;
        end else begin
          s.rel = (sh > 57'(REL_MAX)) ? REL_MAX : sh[39:0];
        end
      end
      nxt[j] = s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j <= LAST; j++) begin
        pipe_r[j] <= nxt[j];
      end
    end
    if (push) begin
      buf_r[wr_ptr_r].stat <= pipe_r[LAST].stat;
      buf_r[wr_ptr_r].rel  <= pipe_r[LAST].rel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      gain_r   <= GAIN_RESET;
      weight_r <= WEIGHT_RESET;
    end else begin
      if (en) begin
        vld_r <= {vld_r[LAST-1:0], in_tvalid};
      end
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN: begin
            gain_r <= cfg_data[15:0];
          end
          REG_WEIGHT: begin
            weight_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[hdl/bts_checker.sv]
// Port-level checks on the result channel of the BM25 term score block.
// Bound to bm25_term_score at the end of this file; depends on bts_pkg.
module bts_checker
  import bts_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or vanished.");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[41:40] == STAT_OK) || (out_tdata[41:40] == STAT_BOOST) ||
                   (out_tdata[41:40] == STAT_STATS))
    else $error("Result carries an undefined status.");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[41:40] != STAT_OK) |-> out_tdata[39:0] == 40'd0)
    else $error("Failed request carries a nonzero score.");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result offered right after reset.");

endmodule

bind bm25_term_score bts_checker u_bts_checker (.*);
